/* src/ssp_pkg.sv */
`default_nettype none

package ssp_pkg;

	localparam int unsigned DimW  = 14;
	localparam int unsigned GapW  = 8;
	localparam int unsigned PosW  = 16;
	localparam int unsigned SizeW = 15;
	localparam int unsigned SumW  = 17;

	localparam logic [DimW-1:0] SHEET_WIDTH_RST  = 14'd512;
	localparam logic [DimW-1:0] SHEET_HEIGHT_RST = 14'd512;
	localparam logic [GapW-1:0] GAP_RST          = 8'd1;

	typedef enum logic [1:0] {
		KIND_PLACED   = 2'd0,
		KIND_CLOSED   = 2'd1,
		KIND_OVERSIZE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_SHEET_WIDTH  = 2'd0,
		REG_SHEET_HEIGHT = 2'd1,
		REG_GAP          = 2'd2
	} reg_idx_t;

	localparam logic CMD_FINISH = 1'b1;

	typedef struct packed {
		logic [SizeW-1:0] height;
		logic [SizeW-1:0] width;
		logic [DimW-1:0]  pos_y;
		logic [DimW-1:0]  pos_x;
		kind_t            kind;
		logic             last;
	} res_t;

	function automatic logic [SizeW-1:0] sat15(input logic [SumW-1:0] v);
		sat15 = (v > {{(SumW-SizeW){1'b0}}, {SizeW{1'b1}}}) ? {SizeW{1'b1}} : v[SizeW-1:0];
	endfunction

endpackage

`default_nettype wire

/* src/shelf_sprite_sheet_placer.sv */
// Channel   Dir  Handshake         Payload
// apb       in   psel/penable      paddr, pwdata, prdata (sheet_width, sheet_height, gap)
// s (cmd)   in   s_tvalid/tready   s_tdata: rect_width, rect_height; s_tuser: command
// m (res)   out  m_tvalid/tready   m_tdata: pos_x, pos_y, out_width, out_height;
//                                  m_tuser: kind; m_tlast: last
//
// An accepted item is registered, then resolved combinationally into the output register.
// One result per cycle is sustained while m_tready is high; an item that closes a sheet
// and then places its rectangle yields two results, the second held in a pending slot.
// The first result of an input transaction passes the input and output registers in turn.
// Reset clears the row state and loads the default sheet size and gap.
// A stalled output holds its result while the input register still takes one more item.
`default_nettype none

module shelf_sprite_sheet_placer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [13:0] rect_width, [27:14] rect_height, [31:28] zero
	input  wire  [0:0]  s_tuser,   // [0] command
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,   // [13:0] pos_x, [27:14] pos_y, [42:28] out_width,
	                               // [57:43] out_height, [63:58] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast
);

	import ssp_pkg::*;

	logic [DimW-1:0] sheet_width_q;
	logic [DimW-1:0] sheet_height_q;
	logic [GapW-1:0] gap_q;

	logic [PosW-1:0] row_x_q;
	logic [PosW-1:0] row_y_q;
	logic [DimW-1:0] row_tallest_q;
	logic [PosW-1:0] widest_row_q;

	logic            valid_s1;
	logic            cmd_s1;
	logic [DimW-1:0] w_s1;
	logic [DimW-1:0] h_s1;

	res_t out_q;
	logic out_valid_q;
	res_t pend_q;
	logic pend_valid_q;

	logic cfg_wr;
	logic issue;
	logic out_free;
	logic s_acc;

	logic [SumW-1:0]  sum_x;
	logic [SumW-1:0]  base_y;
	logic [SumW-1:0]  next_row_y;
	logic [SumW-1:0]  need_y;
	logic [SizeW-1:0] w_gap;
	logic             oversize;
	logic             row_ovf;
	logic             sheet_ovf;
	logic [PosW-1:0]  px;
	logic [PosW-1:0]  py;
	logic [DimW-1:0]  tall;
	logic [PosW-1:0]  new_x;

	res_t            res0;
	res_t            res1;
	logic            two_res;
	logic [PosW-1:0] row_x_d;
	logic [PosW-1:0] row_y_d;
	logic [DimW-1:0] row_tallest_d;
	logic [PosW-1:0] widest_row_d;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_SHEET_WIDTH:  prdata = {{(32-DimW){1'b0}}, sheet_width_q};
			REG_SHEET_HEIGHT: prdata = {{(32-DimW){1'b0}}, sheet_height_q};
			REG_GAP:          prdata = {{(32-GapW){1'b0}}, gap_q};
			default:          prdata = '0;
		endcase
	end

	// A new item resolves only when the output register frees up and no second
	// result is still queued behind it.
	assign out_free = !out_valid_q || m_tready;
	assign issue    = valid_s1 && out_free && !pend_valid_q;
	assign s_tready = !valid_s1 || issue;
	assign s_acc    = s_tvalid && s_tready;

	always_comb begin
		sum_x      = SumW'(row_x_q) + SumW'(w_s1) + SumW'(gap_q);
		base_y     = SumW'(row_y_q) + SumW'(row_tallest_q);
		next_row_y = base_y + SumW'(gap_q);
		need_y     = next_row_y + SumW'(h_s1);
		w_gap      = SizeW'(w_s1) + SizeW'(gap_q);
		oversize   = (w_s1 > sheet_width_q) || (h_s1 > sheet_height_q);
		row_ovf    = sum_x > SumW'(sheet_width_q);
		sheet_ovf  = need_y > SumW'(sheet_height_q);

		px    = row_ovf ? '0 : row_x_q;
		py    = row_ovf ? next_row_y[PosW-1:0] : row_y_q;
		tall  = row_ovf ? '0 : row_tallest_q;
		new_x = row_ovf ? PosW'(w_gap) : sum_x[PosW-1:0];

		row_x_d       = row_x_q;
		row_y_d       = row_y_q;
		row_tallest_d = row_tallest_q;
		widest_row_d  = widest_row_q;
		two_res       = 1'b0;

		res1        = '0;
		res1.kind   = KIND_PLACED;
		res1.last   = 1'b1;

		res0        = '0;
		res0.last   = 1'b1;
		res0.kind   = KIND_PLACED;

		if (cmd_s1 == CMD_FINISH) begin
			res0.kind     = KIND_CLOSED;
			res0.width    = sat15(SumW'(widest_row_q));
			res0.height   = sat15(base_y);
			row_x_d       = '0;
			row_y_d       = '0;
			row_tallest_d = '0;
			widest_row_d  = '0;
		end else if (oversize) begin
			res0.kind   = KIND_OVERSIZE;
			res0.width  = SizeW'(w_s1);
			res0.height = SizeW'(h_s1);
		end else if (row_ovf && sheet_ovf) begin
			// Close the open sheet, then place this rectangle at the origin of a fresh one.
			res0.kind     = KIND_CLOSED;
			res0.last     = 1'b0;
			res0.width    = sat15(SumW'(widest_row_q));
			res0.height   = sat15(next_row_y);
			two_res       = 1'b1;
			row_x_d       = PosW'(w_gap);
			row_y_d       = '0;
			row_tallest_d = h_s1;
			widest_row_d  = PosW'(w_gap);
		end else begin
			res0.pos_x    = px[DimW-1:0];
			res0.pos_y    = py[DimW-1:0];
			row_x_d       = new_x;
			row_y_d       = py;
			row_tallest_d = (h_s1 > tall) ? h_s1 : tall;
			widest_row_d  = (new_x > widest_row_q) ? new_x : widest_row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sheet_width_q  <= SHEET_WIDTH_RST;
			sheet_height_q <= SHEET_HEIGHT_RST;
			gap_q          <= GAP_RST;
			row_x_q        <= '0;
			row_y_q        <= '0;
			row_tallest_q  <= '0;
			widest_row_q   <= '0;
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			pend_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_SHEET_WIDTH:  sheet_width_q  <= pwdata[DimW-1:0];
					REG_SHEET_HEIGHT: sheet_height_q <= pwdata[DimW-1:0];
					REG_GAP:          gap_q          <= pwdata[GapW-1:0];
					default:          ;
				endcase
			end
			if (s_acc) begin
				valid_s1 <= 1'b1;
			end else if (issue) begin
				valid_s1 <= 1'b0;
			end
			if (issue) begin
				row_x_q       <= row_x_d;
				row_y_q       <= row_y_d;
				row_tallest_q <= row_tallest_d;
				widest_row_q  <= widest_row_d;
				out_valid_q   <= 1'b1;
				pend_valid_q  <= two_res;
			end else if (pend_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_s1 <= s_tuser[0];
			w_s1   <= s_tdata[DimW-1:0];
			h_s1   <= s_tdata[2*DimW-1:DimW];
		end
		if (issue) begin
			out_q  <= res0;
			pend_q <= res1;
		end else if (pend_valid_q && out_free) begin
			out_q <= pend_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {{(64-2*DimW-2*SizeW){1'b0}}, out_q.height, out_q.width,
	                   out_q.pos_y, out_q.pos_x};

	a_pend_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("queued second result without a first one in the output register");

	a_pend_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (!m_tlast && m_tuser == KIND_CLOSED))
		else $error("result ahead of a queued placement must be a non-final sheet close");

	a_no_issue_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !issue)
		else $error("item resolved while a second result was still queued");

	a_placed_no_size: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_PLACED) |-> (m_tdata[57:28] == '0))
		else $error("placement result carries a sheet size");

	a_two_results_order: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && two_res) |=> (pend_valid_q && pend_q.pos_x == '0 && pend_q.pos_y == '0))
		else $error("placement after a sheet close is not at the origin");

endmodule

`default_nettype wire
